// ===== rtl/core/vtr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vtr_pkg;

   typedef logic signed [31:0] coord_type;

   typedef struct packed {
      logic mul;
      logic sum;
   } stage_en_type;

   typedef enum logic [2:0] {
      CSR_ROT_X    = 3'd0,
      CSR_ROT_Y    = 3'd1,
      CSR_ROT_Z    = 3'd2,
      CSR_OFFSET_X = 3'd3,
      CSR_OFFSET_Y = 3'd4,
      CSR_OFFSET_Z = 3'd5
   } csr_index_type;

   localparam logic [31:0] ROT_RESET = 32'h4000_0000;
   // floor(m / 5) = (m * DIV5_MAGIC) >> 34 for any 32-bit m
   localparam logic [31:0] DIV5_MAGIC = 32'hCCCC_CCCD;
   localparam int unsigned DIV5_SHIFT = 34;
   localparam logic [31:0] ROUND_BIAS = 32'd10;

   function automatic coord_type sat32(input logic signed [34:0] v);
      coord_type r;
      if (v > 35'sd2147483647) begin
         r = 32'sh7fff_ffff;
      end else if (v < -35'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vtr_rot_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

// p = c*a - s*b, q = s*a + c*b, rounded from Q18.30 to Q16.16 and saturated
module vtr_rot_stage (
   input  wire                         clock,
   input  wire vtr_pkg::stage_en_type  en,
   input  wire [31:0]                  cos_sin,
   input  wire vtr_pkg::coord_type     a,
   input  wire vtr_pkg::coord_type     b,
   output vtr_pkg::coord_type          p,
   output vtr_pkg::coord_type          q
);
   import vtr_pkg::*;

   logic signed [15:0] cos_w;
   logic signed [15:0] sin_w;
   logic signed [47:0] ca_ff, sb_ff, sa_ff, cb_ff;
   logic signed [48:0] p_sum, q_sum;
   logic signed [34:0] p_rnd, q_rnd;
   coord_type          p_in, q_in, p_ff, q_ff;

   assign cos_w = cos_sin[31:16];
   assign sin_w = cos_sin[15:0];

   always_ff @(posedge clock) begin
      if (en.mul) begin
         ca_ff <= 48'(cos_w) * 48'(a);
         sb_ff <= 48'(sin_w) * 48'(b);
         sa_ff <= 48'(sin_w) * 48'(a);
         cb_ff <= 48'(cos_w) * 48'(b);
      end
   end

   always_comb begin
      p_sum = {ca_ff[47], ca_ff} - {sb_ff[47], sb_ff} + 49'sd8192;
      q_sum = {sa_ff[47], sa_ff} + {cb_ff[47], cb_ff} + 49'sd8192;
      p_rnd = p_sum[48:14];
      q_rnd = q_sum[48:14];
      p_in  = sat32(p_rnd);
      q_in  = sat32(q_rnd);
   end

   always_ff @(posedge clock) begin
      if (en.sum) begin
         p_ff <= p_in;
         q_ff <= q_in;
      end
   end

   assign p = p_ff;
   assign q = q_ff;

endmodule

`default_nettype wire

// ===== rtl/core/vtr_offset_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none

// offset / 20, nearest, ties away from zero; three lanes, three stages
module vtr_offset_scale (
   input  wire                  clock,
   input  wire [2:0]            en,
   input  wire [2:0][31:0]      offset,
   output logic [2:0][27:0]     step
);
   import vtr_pkg::*;

   logic [2:0]        neg1_ff, neg2_ff;
   logic [2:0][29:0]  quarter_ff;
   logic [2:0][61:0]  prod_ff;
   logic [2:0][31:0]  mag_in;
   logic [2:0][31:0]  biased_in;
   logic [2:0][26:0]  quot;
   logic [2:0][27:0]  step_in;
   logic [2:0][27:0]  step_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_in[i]    = offset[i][31] ? (~offset[i] + 32'd1) : offset[i];
         biased_in[i] = mag_in[i] + ROUND_BIAS;
         quot[i]      = prod_ff[i][DIV5_SHIFT +: 27];
         step_in[i]   = neg2_ff[i] ? (~{1'b0, quot[i]} + 28'd1) : {1'b0, quot[i]};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (en[0]) begin
            quarter_ff[i] <= biased_in[i][31:2];
            neg1_ff[i]    <= offset[i][31];
         end
         if (en[1]) begin
            prod_ff[i] <= {32'd0, quarter_ff[i]} * {30'd0, DIV5_MAGIC};
            neg2_ff[i] <= neg1_ff[i];
         end
         if (en[2]) begin
            step_ff[i] <= step_in[i];
         end
      end
   end

   assign step = step_ff;

endmodule

`default_nettype wire

// ===== rtl/core/vertex_translate_rotate_xyz_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Transforms one Q16.16 vertex per request: req_tuser 0 adds 0.05 times the
// configured offsets, 1 rotates about X, then Y, then Z with the configured
// Q2.14 cosine/sine pairs; every coordinate saturates to 32 bits and tlast
// passes through. The six-stage pipeline takes a new request every cycle
// while rsp_tready stays high; on each path, each stage holds at most one
// multiply (16x32 for rotation, 30x32 reciprocal for the offset scaling) or
// one add-round-saturate. A stall holds each full stage whose later stages
// are all full, and empty stages fill in behind them. Write the CSRs only
// while no request is in flight.
module vertex_translate_rotate_xyz_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [95:0]  req_tdata,   // in_x, in_y, in_z
   input  wire         req_tuser,   // action
   input  wire         req_tlast,   // in_last
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [95:0] rsp_tdata,   // out_x, out_y, out_z
   output logic        rsp_tlast,   // out_last
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire [2:0]   csr_index,
   input  wire [31:0]  csr_data
);
   import vtr_pkg::*;

   localparam int unsigned STAGES = 6;

   logic [31:0] rot_x_ff, rot_y_ff, rot_z_ff;
   logic [2:0][31:0] offset_ff;

   logic [STAGES:1] valid_ff;
   logic [STAGES:1] en;
   logic [STAGES:1] act_ff;
   logic [STAGES:1] last_ff;

   coord_type in_x, in_y, in_z;
   coord_type x1_ff, y1_ff, z1_ff, x2_ff, y2_ff, z2_ff, x3_ff, y3_ff, z3_ff;
   coord_type yr3_ff, yr4_ff, zr5_ff, zr6_ff;
   coord_type tx_in, ty_in, tz_in;
   coord_type tx4_ff, ty4_ff, tz4_ff, tx5_ff, ty5_ff, tz5_ff, tx6_ff, ty6_ff, tz6_ff;
   coord_type rx_y, rx_z, ry_z, ry_x, rz_y, rz_x;
   logic [2:0][27:0] step;

   stage_en_type en_x, en_y, en_z;

   assign in_x = req_tdata[31:0];
   assign in_y = req_tdata[63:32];
   assign in_z = req_tdata[95:64];

   // csr
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_x_ff  <= ROT_RESET;
         rot_y_ff  <= ROT_RESET;
         rot_z_ff  <= ROT_RESET;
         offset_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ROT_X:    rot_x_ff     <= csr_data;
            CSR_ROT_Y:    rot_y_ff     <= csr_data;
            CSR_ROT_Z:    rot_z_ff     <= csr_data;
            CSR_OFFSET_X: offset_ff[0] <= csr_data;
            CSR_OFFSET_Y: offset_ff[1] <= csr_data;
            CSR_OFFSET_Z: offset_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // stage enables: a stage moves when it is empty or the next one moves
   always_comb begin
      en[STAGES] = !valid_ff[STAGES] || rsp_tready;
      for (int i = STAGES - 1; i >= 1; i--) begin
         en[i] = !valid_ff[i] || en[i + 1];
      end
   end

   assign req_tready = en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[1]) valid_ff[1] <= req_tvalid;
         for (int i = 2; i <= STAGES; i++) begin
            if (en[i]) valid_ff[i] <= valid_ff[i - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         act_ff[1]  <= req_tuser;
         last_ff[1] <= req_tlast;
      end
      for (int i = 2; i <= STAGES; i++) begin
         if (en[i]) begin
            act_ff[i]  <= act_ff[i - 1];
            last_ff[i] <= last_ff[i - 1];
         end
      end
   end

   // rotation path
   assign en_x = '{mul: en[1], sum: en[2]};
   assign en_y = '{mul: en[3], sum: en[4]};
   assign en_z = '{mul: en[5], sum: en[6]};

   vtr_rot_stage u_rot_x (
      .clock   (clock),
      .en      (en_x),
      .cos_sin (rot_x_ff),
      .a       (in_y),
      .b       (in_z),
      .p       (rx_y),
      .q       (rx_z)
   );

   vtr_rot_stage u_rot_y (
      .clock   (clock),
      .en      (en_y),
      .cos_sin (rot_y_ff),
      .a       (rx_z),
      .b       (x2_ff),
      .p       (ry_z),
      .q       (ry_x)
   );

   vtr_rot_stage u_rot_z (
      .clock   (clock),
      .en      (en_z),
      .cos_sin (rot_z_ff),
      .a       (yr4_ff),
      .b       (ry_x),
      .p       (rz_y),
      .q       (rz_x)
   );

   // translate path
   vtr_offset_scale u_offset_scale (
      .clock  (clock),
      .en     (en[3:1]),
      .offset (offset_ff),
      .step   (step)
   );

   always_comb begin
      tx_in = sat32({{3{x3_ff[31]}}, x3_ff} + {{7{step[0][27]}}, step[0]});
      ty_in = sat32({{3{y3_ff[31]}}, y3_ff} + {{7{step[1][27]}}, step[1]});
      tz_in = sat32({{3{z3_ff[31]}}, z3_ff} + {{7{step[2][27]}}, step[2]});
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         x1_ff <= in_x;
         y1_ff <= in_y;
         z1_ff <= in_z;
      end
      if (en[2]) begin
         x2_ff <= x1_ff;
         y2_ff <= y1_ff;
         z2_ff <= z1_ff;
      end
      if (en[3]) begin
         x3_ff  <= x2_ff;
         y3_ff  <= y2_ff;
         z3_ff  <= z2_ff;
         yr3_ff <= rx_y;
      end
      if (en[4]) begin
         tx4_ff <= tx_in;
         ty4_ff <= ty_in;
         tz4_ff <= tz_in;
         yr4_ff <= yr3_ff;
      end
      if (en[5]) begin
         tx5_ff <= tx4_ff;
         ty5_ff <= ty4_ff;
         tz5_ff <= tz4_ff;
         zr5_ff <= ry_z;
      end
      if (en[6]) begin
         tx6_ff <= tx5_ff;
         ty6_ff <= ty5_ff;
         tz6_ff <= tz5_ff;
         zr6_ff <= zr5_ff;
      end
   end

   assign rsp_tvalid = valid_ff[STAGES];
   assign rsp_tlast  = last_ff[STAGES];
   assign rsp_tdata  = act_ff[STAGES] ? {zr6_ff, rz_y, rz_x} : {tz6_ff, ty6_ff, tx6_ff};

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import vtr_pkg::*;

   localparam logic ACT_TRANSLATE = 1'b0;
   localparam logic ACT_ROTATE    = 1'b1;
   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;
   localparam coord_type C_MAX = 32'sh7fff_ffff;
   localparam coord_type C_MIN = 32'sh8000_0000;
   localparam int PIPE_DEPTH     = 6;
   localparam int TOTAL_VERTICES = 1750;
   localparam int QUIET_FROM     = 1450;
   localparam int HOLD_AT        = 400;
   localparam int HOLD_CYCLES    = 150;

   typedef struct packed {
      logic      action;
      coord_type x;
      coord_type y;
      coord_type z;
      logic      last;
   } vertex_in_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
      logic      last;
   } vertex_out_type;

   typedef enum logic {ROW_CSR, ROW_VERTEX} row_kind_type;

   typedef struct {
      row_kind_type   kind;
      logic [2:0]     index;
      logic [31:0]    value;
      vertex_in_type  vin;
      bit             typed;
      vertex_out_type vout;
   } script_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   logic [31:0] rot_x_pair = ROT_RESET;
   logic [31:0] rot_y_pair = ROT_RESET;
   logic [31:0] rot_z_pair = ROT_RESET;
   coord_type   move_x = '0;
   coord_type   move_y = '0;
   coord_type   move_z = '0;

   vertex_out_type vertices_due[$];
   script_row_type script[$];
   int          vertices_sent = 0;
   int          mismatches = 0;
   bit          quiet = 1'b0;
   bit          bursty = 1'b1;
   bit          hold_done = 1'b0;

   vertex_translate_rotate_xyz_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic coord_type clamp32(input longint v);
      if (v > 64'sd2147483647) return C_MAX;
      if (v < -64'sd2147483648) return C_MIN;
      return coord_type'(v[31:0]);
   endfunction

   // offset / 20, nearest, ties away from zero
   function automatic longint scaled_offset(input coord_type o);
      longint m;
      m = longint'(o);
      if (m >= 0) return (m + 10) / 20;
      return -((-m + 10) / 20);
   endfunction

   // p' = c*p + s*q, q' = c*q - s*p; flip negates s (X-axis convention)
   function automatic void spin(input logic [31:0] cs, input bit flip,
                                inout coord_type p, inout coord_type q);
      longint c, s, np, nq;
      c = longint'($signed(cs[31:16]));
      s = longint'($signed(cs[15:0]));
      if (flip) s = -s;
      np = c * longint'(p) + s * longint'(q) + 8192;
      nq = c * longint'(q) - s * longint'(p) + 8192;
      p = clamp32(np >>> 14);
      q = clamp32(nq >>> 14);
   endfunction

   function automatic vertex_out_type transform_vertex(input vertex_in_type v);
      vertex_out_type r;
      coord_type      x, y, z;
      x = v.x;
      y = v.y;
      z = v.z;
      if (v.action == ACT_TRANSLATE) begin
         x = clamp32(longint'(x) + scaled_offset(move_x));
         y = clamp32(longint'(y) + scaled_offset(move_y));
         z = clamp32(longint'(z) + scaled_offset(move_z));
      end else begin
         spin(rot_x_pair, 1'b1, y, z);
         spin(rot_y_pair, 1'b0, x, z);
         spin(rot_z_pair, 1'b0, x, y);
      end
      r.x = x;
      r.y = y;
      r.z = z;
      r.last = v.last;
      return r;
   endfunction

   function automatic void apply_write(input logic [2:0] idx, input logic [31:0] val);
      case (idx)
         CSR_ROT_X:    rot_x_pair = val;
         CSR_ROT_Y:    rot_y_pair = val;
         CSR_ROT_Z:    rot_z_pair = val;
         CSR_OFFSET_X: move_x = val;
         CSR_OFFSET_Y: move_y = val;
         CSR_OFFSET_Z: move_z = val;
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s expected %h got %h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : check_rsp
      vertex_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (vertices_due.size() == 0) begin
            $error("response with no request pending: %h", rsp_tdata);
            mismatches++;
         end else begin
            want = vertices_due.pop_front();
            check_field("out_x", want.x, rsp_tdata[31:0]);
            check_field("out_y", want.y, rsp_tdata[63:32]);
            check_field("out_z", want.z, rsp_tdata[95:64]);
            check_field("out_last", want.last, rsp_tlast);
         end
      end
   end

   // response side: random back-pressure plus one long hold
   initial begin : consumer
      @(posedge clock);
      forever begin
         if (!hold_done && vertices_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   function automatic void add_write(input logic [2:0] idx, input logic [31:0] val);
      script_row_type r;
      r.kind = ROW_CSR;
      r.index = idx;
      r.value = val;
      r.vin = '0;
      r.typed = 1'b0;
      r.vout = '0;
      script.push_back(r);
   endfunction

   function automatic void add_vertex(input logic act, input coord_type px, input coord_type py,
                                      input coord_type pz, input logic lst);
      script_row_type r;
      r.kind = ROW_VERTEX;
      r.index = '0;
      r.value = '0;
      r.vin = '{action: act, x: px, y: py, z: pz, last: lst};
      r.typed = 1'b0;
      r.vout = '0;
      script.push_back(r);
   endfunction

   function automatic void add_checked(input logic act, input coord_type px,
                                       input coord_type py, input coord_type pz,
                                       input logic lst, input coord_type ex,
                                       input coord_type ey, input coord_type ez);
      add_vertex(act, px, py, pz, lst);
      script[script.size() - 1].typed = 1'b1;
      script[script.size() - 1].vout = '{x: ex, y: ey, z: ez, last: lst};
   endfunction

   function automatic coord_type pick_coord();
      case ($urandom_range(0, 5))
         0: return C_MAX;
         1: return C_MIN;
         2: return coord_type'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_rot();
      logic [15:0] c, s;
      case ($urandom_range(0, 5))
         0: return ROT_RESET;
         1: return $urandom_range(0, 1) ? 32'h8000_8000 : 32'h7fff_7fff;
         2, 3: begin
            c = 16'($urandom_range(0, 16384));
            s = 16'($urandom_range(0, 16384));
            if ($urandom_range(0, 1)) c = -c;
            if ($urandom_range(0, 1)) s = -s;
            return {c, s};
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic coord_type pick_offset();
      coord_type o;
      case ($urandom_range(0, 5))
         0: return C_MAX;
         1: return C_MIN;
         2: begin
            // halfway cases of the divide by 20
            o = coord_type'(20 * $urandom_range(0, 100000) + 10);
            return $urandom_range(0, 1) ? -o : o;
         end
         3: return coord_type'($urandom_range(0, 4000)) - 32'sd2000;
         default: return $urandom;
      endcase
   endfunction

   task automatic write_csr(input logic [2:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_write(idx, val);
   endtask

   task automatic send_vertex(input vertex_in_type v, input bit typed,
                              input vertex_out_type fixed);
      int gap;
      gap = (!bursty || quiet || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {v.z, v.y, v.x};
      req_tuser <= v.action;
      req_tlast <= v.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      vertices_due.push_back(typed ? fixed : transform_vertex(v));
      vertices_sent++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (vertices_due.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 2) @(posedge clock);
   endtask

   initial begin : stimulus
      vertex_in_type v;
      bit            in_flight;
      int            n_items;
      in_flight = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings leave the vertex untouched
      add_checked(ACT_TRANSLATE, C_MAX, C_MIN, 32'sd1, 1'b1, C_MAX, C_MIN, 32'sd1);
      add_checked(ACT_ROTATE, C_MIN, C_MAX, -32'sd1, 1'b0, C_MIN, C_MAX, -32'sd1);
      add_vertex(ACT_ROTATE, 32'sh0001_8000, -32'sh0003_0000, 32'sh0000_0001, 1'b0);
      // extreme offsets saturate the sum
      add_write(CSR_OFFSET_X, C_MAX);
      add_write(CSR_OFFSET_Y, C_MIN);
      add_write(CSR_OFFSET_Z, 32'd20);
      add_write(CSR_SPARE_LO, 32'h0);
      add_checked(ACT_TRANSLATE, C_MAX, C_MIN, 32'sd5, 1'b1, C_MAX, C_MIN, 32'sd6);
      add_vertex(ACT_TRANSLATE, C_MIN, C_MAX, -32'sd1, 1'b0);
      // halfway offsets round away from zero
      add_write(CSR_OFFSET_X, 32'd10);
      add_write(CSR_OFFSET_Y, -32'sd10);
      add_write(CSR_OFFSET_Z, 32'd9);
      add_checked(ACT_TRANSLATE, 32'sd0, 32'sd0, 32'sd0, 1'b1, 32'sd1, -32'sd1, 32'sd0);
      add_checked(ACT_TRANSLATE, C_MAX, C_MIN, C_MAX, 1'b0, C_MAX, C_MIN, C_MAX);
      // non-unit pairs at the range limits
      add_write(CSR_SPARE_HI, 32'hffff_ffff);
      add_write(CSR_ROT_X, 32'h8000_8000);
      add_write(CSR_ROT_Y, 32'h7fff_7fff);
      add_write(CSR_ROT_Z, 32'h0000_4000);
      add_vertex(ACT_ROTATE, C_MAX, C_MAX, C_MAX, 1'b1);
      add_vertex(ACT_ROTATE, C_MIN, C_MIN, C_MIN, 1'b0);
      add_vertex(ACT_ROTATE, C_MAX, C_MIN, 32'sd0, 1'b1);
      add_vertex(ACT_ROTATE, 32'sh0001_0000, -32'sh0001_0000, 32'sh0000_7fff, 1'b0);
      // all-zero pairs collapse the vertex
      add_write(CSR_ROT_X, 32'h0);
      add_write(CSR_ROT_Y, 32'h0);
      add_write(CSR_ROT_Z, 32'h0);
      add_checked(ACT_ROTATE, C_MAX, C_MIN, 32'sd1234567, 1'b1, 32'sd0, 32'sd0, 32'sd0);
      // quarter turns about X and Z
      add_write(CSR_ROT_X, 32'h0000_c000);
      add_write(CSR_ROT_Y, ROT_RESET);
      add_write(CSR_ROT_Z, 32'h0000_4000);
      add_vertex(ACT_ROTATE, 32'sh0002_0000, 32'sh0003_0000, -32'sh0005_0000, 1'b0);
      add_vertex(ACT_ROTATE, 32'sh0000_0001, 32'sh0000_2001, -32'sh0000_3fff, 1'b1);
      add_vertex(ACT_TRANSLATE, -32'sd7, 32'sd7, C_MIN, 1'b0);

      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            if (in_flight) begin
               settle();
               in_flight = 1'b0;
            end
            write_csr(script[i].index, script[i].value);
            if (i + 1 == script.size() || script[i + 1].kind != ROW_CSR) csr_valid <= 1'b0;
         end else begin
            send_vertex(script[i].vin, script[i].typed, script[i].vout);
            in_flight = 1'b1;
         end
      end

      while (vertices_sent < TOTAL_VERTICES) begin
         if (vertices_sent < QUIET_FROM) begin
            settle();
            if ($urandom_range(0, 3) != 0) write_csr(CSR_ROT_X, pick_rot());
            if ($urandom_range(0, 3) != 0) write_csr(CSR_ROT_Y, pick_rot());
            if ($urandom_range(0, 3) != 0) write_csr(CSR_ROT_Z, pick_rot());
            if ($urandom_range(0, 3) != 0) write_csr(CSR_OFFSET_X, pick_offset());
            if ($urandom_range(0, 3) != 0) write_csr(CSR_OFFSET_Y, pick_offset());
            if ($urandom_range(0, 3) != 0) write_csr(CSR_OFFSET_Z, pick_offset());
            if ($urandom_range(0, 5) == 0) write_csr(CSR_SPARE_HI, $urandom);
            csr_valid <= 1'b0;
         end
         bursty = $urandom_range(0, 2) != 0;
         n_items = $urandom_range(40, 200);
         // keep offering well past the point where the long hold starts
         if (vertices_sent < HOLD_AT && vertices_sent + n_items >= HOLD_AT) n_items += 64;
         if (n_items > TOTAL_VERTICES - vertices_sent) n_items = TOTAL_VERTICES - vertices_sent;
         repeat (n_items) begin
            quiet = vertices_sent >= QUIET_FROM;
            v.action = $urandom_range(0, 1);
            v.x = pick_coord();
            v.y = pick_coord();
            v.z = pick_coord();
            v.last = $urandom_range(0, 7) == 0;
            send_vertex(v, 1'b0, '0);
         end
      end

      settle();
      if (mismatches == 0 && vertices_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
